// File: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, constants and hash steps for the cuckoo hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned SlotsDef     = 1024;
  localparam int unsigned KeyBytesDef  = 8;
  localparam int unsigned ValueBitsDef = 32;

  localparam logic [31:0] H1Seed   = 32'h0000_1505;
  localparam logic [31:0] FnvBasis = 32'h811c_9dc5;
  localparam logic [31:0] FnvPrime = 32'h0100_0193;
  localparam int unsigned H1Shift  = 5;

  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpDelete = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFail = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_PROBE1,
    S_CHECK1,
    S_CHECK2,
    S_KHASH,
    S_KREAD,
    S_KSWAP,
    S_CLEAR,
    S_OUT
  } state_e;

  function automatic logic [31:0] h1_step(input logic [31:0] h, input logic [7:0] b);
    h1_step = (h << H1Shift) ^ {24'd0, b};
  endfunction

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    fnv_step = (h ^ {24'd0, b}) * FnvPrime;
  endfunction

endpackage

// File: rtl/cuckoo_hash_table.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Two-half cuckoo hash table: lookup, insert with displacement, delete, clear.
// ----------------------------------------------------------------------------
// Operation: lookup, delete and insert of a present key hash the key, one hash
// byte a cycle, then do one read per half. Each displacement rehashes and
// rereads the evicted key. Clear walks the occupied bits slot by slot.
// One word in flight; reset clears the occupied bits by the same walk.
module cuckoo_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned Slots     = SlotsDef,
  parameter int unsigned KeyBytes  = KeyBytesDef,
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], key_bytes[65:2], key_length[69:66], value[101:70], zero fill
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], slot[11:2], occupied_count[22:12], zero fill
  output logic [23:0]  m_axis_tdata
);

  localparam int unsigned SW   = $clog2(Slots);
  localparam int unsigned KW   = 8 * KeyBytes;
  localparam int unsigned LW   = $clog2(KeyBytes + 1);
  localparam int unsigned CW   = SW + 1;
  localparam int unsigned RW   = $clog2(Slots / 4 + 1);
  localparam logic [SW-1:0] HalfMask = SW'(Slots / 2 - 1);
  localparam logic [SW-1:0] HalfOff  = SW'(Slots / 2);

  logic [KW-1:0]        mem_key   [Slots];
  logic [LW-1:0]        mem_len   [Slots];
  logic [ValueBits-1:0] mem_val   [Slots];
  logic                 mem_occ   [Slots];

  state_e               state_q, state_d;
  logic [1:0]           op_q;
  logic [KW-1:0]        key_q, key_d;
  logic [LW-1:0]        len_q, len_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic [LW-1:0]        bi_q, bi_d;
  logic [31:0]          h1_q, h1_d, h2_q, h2_d;
  logic [SW-1:0]        addr_q, addr_d, i2_q, i2_d;
  logic [SW-1:0]        rd_addr;
  logic                 second_q, second_d;
  logic [RW-1:0]        rounds_q, rounds_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [1:0]           st_q, st_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [SW:0]          clr_q, clr_d;
  logic [KW-1:0]        rk_q;
  logic [LW-1:0]        rl_q;
  logic [ValueBits-1:0] rv_q;
  logic                 ro_q;
  logic                 we, occ_we, occ_wd;
  logic [SW-1:0]        occ_wa;
  logic [KW-1:0]        in_key, in_mask;
  logic [LW-1:0]        in_len;
  logic [3:0]           raw_len;
  logic [7:0]           cur_byte;
  logic                 hit;

  assign raw_len = s_axis_tdata[69:66];
  assign in_len  = (raw_len > 4'(KeyBytes)) ? LW'(KeyBytes) : LW'(raw_len);
  always_comb begin
    in_mask = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (i < int'(in_len)) in_mask[8*i +: 8] = 8'hff;
    end
  end
  assign in_key   = s_axis_tdata[2 +: KW] & in_mask;
  assign cur_byte = key_q[8*bi_q[LW-1:0] +: 8];
  assign hit      = ro_q && (rl_q == len_q) && (rk_q == key_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_key[addr_q] <= key_q;
      mem_len[addr_q] <= len_q;
      mem_val[addr_q] <= val_q;
    end
    if (occ_we) mem_occ[occ_wa] <= occ_wd;
    rk_q <= mem_key[rd_addr];
    rl_q <= mem_len[rd_addr];
    rv_q <= mem_val[rd_addr];
    ro_q <= mem_occ[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      clr_q   <= '0;
      op_q    <= OpLookup;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      if (state_q == S_IDLE && s_axis_tvalid) op_q <= s_axis_tdata[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    len_q    <= len_d;
    val_q    <= val_d;
    bi_q     <= bi_d;
    h1_q     <= h1_d;
    h2_q     <= h2_d;
    addr_q   <= addr_d;
    i2_q     <= i2_d;
    second_q <= second_d;
    rounds_q <= rounds_d;
    st_q     <= st_d;
    slot_q   <= slot_d;
  end

  always_comb begin
    state_d  = state_q;
    key_d    = key_q;
    len_d    = len_q;
    val_d    = val_q;
    bi_d     = bi_q;
    h1_d     = h1_q;
    h2_d     = h2_q;
    addr_d   = addr_q;
    i2_d     = i2_q;
    second_d = second_q;
    rounds_d = rounds_q;
    cnt_d    = cnt_q;
    st_d     = st_q;
    slot_d   = slot_q;
    clr_d    = clr_q;
    rd_addr  = addr_q;
    we       = 1'b0;
    occ_we   = 1'b0;
    occ_wa   = addr_q;
    occ_wd   = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          key_d  = in_key;
          len_d  = in_len;
          val_d  = ValueBits'(s_axis_tdata[70 +: (ValueBits < 32 ? ValueBits : 32)]);
          bi_d   = '0;
          h1_d   = H1Seed;
          h2_d   = FnvBasis;
          st_d   = StOk;
          slot_d = '0;
          clr_d  = '0;
          state_d = (s_axis_tdata[1:0] == OpClear) ? S_CLEAR : S_HASH;
        end
      end
      S_HASH, S_KHASH: begin
        if (bi_q < len_q) begin
          h1_d = h1_step(h1_q, cur_byte);
          h2_d = fnv_step(h2_q, cur_byte);
          bi_d = bi_q + 1'b1;
        end else if (state_q == S_HASH) begin
          addr_d  = h1_q[SW-1:0] & HalfMask;
          i2_d    = (h2_q[SW-1:0] & HalfMask) + HalfOff;
          rd_addr = h1_q[SW-1:0] & HalfMask;
          state_d = S_PROBE1;
        end else begin
          addr_d  = second_q ? ((h2_q[SW-1:0] & HalfMask) + HalfOff)
                             : (h1_q[SW-1:0] & HalfMask);
          rd_addr = addr_d;
          state_d = S_KREAD;
        end
      end
      S_PROBE1: begin
        rd_addr = addr_q;
        state_d = S_CHECK1;
      end
      S_CHECK1: begin
        rd_addr = i2_q;
        if (hit) begin
          slot_d  = addr_q;
          state_d = S_CHECK2;
          bi_d    = '1;
        end else begin
          bi_d    = '0;
          state_d = S_CHECK2;
        end
      end
      S_CHECK2: begin
        if (bi_q == '1 || hit) begin
          if (bi_q != '1) slot_d = i2_q;
          if (op_q == OpDelete) begin
            occ_we = 1'b1;
            occ_wa = (bi_q == '1) ? slot_q : i2_q;
            if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
          end
          state_d = S_OUT;
        end else if (op_q == OpInsert) begin
          second_d = 1'b0;
          rounds_d = RW'(Slots / 4);
          rd_addr  = addr_q;
          state_d  = S_KREAD;
        end else begin
          st_d    = StMiss;
          state_d = S_OUT;
        end
      end
      S_KREAD: state_d = S_KSWAP;
      S_KSWAP: begin
        we     = 1'b1;
        occ_we = 1'b1;
        occ_wd = 1'b1;
        if (!ro_q) begin
          cnt_d   = cnt_q + 1'b1;
          slot_d  = addr_q;
          state_d = S_OUT;
        end else begin
          key_d  = rk_q;
          len_d  = rl_q;
          val_d  = rv_q;
          second_d = !second_q;
          if (second_q) rounds_d = rounds_q - 1'b1;
          if (second_q && rounds_q == RW'(1)) begin
            st_d    = StFail;
            slot_d  = '0;
            state_d = S_OUT;
          end else begin
            bi_d    = '0;
            h1_d    = H1Seed;
            h2_d    = FnvBasis;
            state_d = S_KHASH;
          end
        end
      end
      S_CLEAR: begin
        occ_we = 1'b1;
        occ_wa = clr_q[SW-1:0];
        clr_d  = clr_q + 1'b1;
        cnt_d  = '0;
        if (clr_q == (SW+1)'(Slots - 1)) begin
          st_d    = StOk;
          slot_d  = '0;
          state_d = (op_q == OpClear) ? S_OUT : S_IDLE;
        end
      end
      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_axis_tdata        = '0;
    m_axis_tdata[1:0]   = st_q;
    m_axis_tdata[11:2]  = 10'(slot_q);
    m_axis_tdata[22:12] = 11'(cnt_q);
  end

endmodule
